// ===== sv/sktab_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the sorted keyed table.
// No dependencies; the cell and the top level import this package.
package sktab_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Broadcast command from the control to every cell
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_CMP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_ROTATE = 3'd4
  } cmd_e;

  typedef struct packed {
    logic signed [31:0] id;
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [31:0]        name_high;
    logic signed [31:0] stock;
  } entry_t;

  typedef struct packed {
    cmd_e   cmd;
    logic   head_le;   // new id is at most the head id
    logic   del_last;  // remove the tail entry only
    entry_t ent;       // new entry; its id is the compare key
  } cell_cmd_t;

  typedef struct packed {
    logic ge_cmp;      // stored id >= key
    logic match;       // occupied and stored id == key
    logic last_match;  // match on the tail entry
  } cell_flags_t;

endpackage

// ===== sv/sktab_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sorted keyed table.
// No dependencies.
interface sktab_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] item_id;
  logic [63:0]        name_low;
  logic [63:0]        name_mid;
  logic [31:0]        name_high;
  logic signed [31:0] stock_amount;

  modport source (
    output valid, operation, item_id, name_low, name_mid, name_high, stock_amount,
    input  ready
  );
  modport sink (
    input  valid, operation, item_id, name_low, name_mid, name_high, stock_amount,
    output ready
  );
endinterface

interface sktab_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_id;
  logic [63:0]        out_name_low;
  logic [63:0]        out_name_mid;
  logic [31:0]        out_name_high;
  logic signed [31:0] out_stock;
  logic [1:0]         status;
  logic               last_result;

  modport source (
    output valid, out_id, out_name_low, out_name_mid, out_name_high, out_stock,
           status, last_result,
    input  ready
  );
  modport sink (
    input  valid, out_id, out_name_low, out_name_mid, out_name_high, out_stock,
           status, last_result,
    output ready
  );
endinterface

// ===== sv/sktab_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted table: holds an entry, compares it against the
// broadcast key and moves data to or from its neighbors. Uses sktab_pkg.
module sktab_cell import sktab_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int IDX         = 0
) (
  input  logic                               clk_i,
  input  cell_cmd_t                          cmd_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     last_idx_i,
  input  entry_t                             prev_ent_i,
  input  logic                               prev_ge_i,
  input  entry_t                             next_ent_i,
  input  entry_t                             head_ent_i,
  output entry_t                             ent_o,
  output logic                               ge_ins_o,
  output cell_flags_t                        flags_o
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t ent_q, ent_d;
  logic   gt_q, ge_q, eq_q;
  logic   occ, is_last;

  assign occ     = CW'(IDX) < count_i;
  assign is_last = IW'(IDX) == last_idx_i;

  // At or past the insert point: empty slot, insert at head, or larger id
  assign ge_ins_o = !occ || cmd_i.head_le || gt_q;

  always_comb begin
    ent_d = ent_q;
    unique case (cmd_i.cmd)
      CMD_HOLD, CMD_CMP: begin
      end
      CMD_INSERT: begin
        if (ge_ins_o) begin
          ent_d = prev_ge_i ? prev_ent_i : cmd_i.ent;
        end
      end
      CMD_DELETE: begin
        // close the gap from the first match upward
        if (!cmd_i.del_last && occ && ge_q) begin
          ent_d = next_ent_i;
        end
      end
      CMD_ROTATE: begin
        ent_d = is_last ? head_ent_i : next_ent_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (cmd_i.cmd == CMD_CMP) begin
      gt_q <= $signed(ent_q.id) >  $signed(cmd_i.ent.id);
      ge_q <= $signed(ent_q.id) >= $signed(cmd_i.ent.id);
      eq_q <= ent_q.id == cmd_i.ent.id;
    end
  end

  assign ent_o              = ent_q;
  assign flags_o.ge_cmp     = ge_q;
  assign flags_o.match      = eq_q && occ;
  assign flags_o.last_match = eq_q && occ && is_last;

endmodule

// ===== sv/sorted_keyed_table.sv =====
`timescale 1ns / 1ps
// Top level of the sorted keyed table: control FSM, row of cells, output register.
// Depends on sktab_pkg, sktab_if and sktab_cell.
//
//  channel | direction | handshake    | payload
//  req_i   | in        | valid/ready  | operation, item_id, name_low/mid/high, stock_amount
//  rsp_o   | out       | valid/ready  | out_id, out_name_*, out_stock, status, last_result
//
// Insert and delete go from acceptance through a compare in every cell, a move
// of entries and the registering of the result.
// Dump emits each stored entry in turn from cell 0: the row rotates one slot toward cell 0.
// Reset clears the entry count, FSM and output valid; stored entries are not cleared.
// A stalled result holds the output register; dump rotation waits with it.
module sorted_keyed_table import sktab_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sktab_req_if.sink    req_i,
  sktab_rsp_if.source  rsp_o
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_APPLY = 5'b00100,
    S_RESP  = 5'b01000,
    S_DUMP  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  entry_t           ent_q;
  logic [CW-1:0]    count_q, count_d;
  status_e          status_q, status_d;
  logic [IW-1:0]    dump_idx_q, dump_idx_d;
  logic [IW-1:0]    last_idx;

  logic             rsp_valid_q;
  entry_t           rsp_ent_q;
  status_e          rsp_status_q;
  logic             rsp_last_q;

  cell_cmd_t        cmd;
  entry_t           ent_vec  [TABLE_DEPTH];
  logic             ge_vec   [TABLE_DEPTH];
  cell_flags_t      flag_vec [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_vec, last_vec;

  logic accept, slot_free, full, found, load_rsp, load_dump;

  assign req_i.ready = state_q == S_IDLE;
  assign accept      = req_i.valid && req_i.ready;
  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign last_idx    = IW'(count_q - CW'(1));
  assign full        = count_q == CW'(TABLE_DEPTH);
  assign found       = |match_vec;

  // ---------------- cell row ----------------
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t prev_ent, next_ent;
    logic   prev_ge;

    if (g == 0) begin : g_first
      assign prev_ent = cmd.ent;
      assign prev_ge  = 1'b0;
    end else begin : g_mid
      assign prev_ent = ent_vec[g-1];
      assign prev_ge  = ge_vec[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign next_ent = ent_vec[g];
    end else begin : g_body
      assign next_ent = ent_vec[g+1];
    end

    sktab_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX         (g)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .count_i    (count_q),
      .last_idx_i (last_idx),
      .prev_ent_i (prev_ent),
      .prev_ge_i  (prev_ge),
      .next_ent_i (next_ent),
      .head_ent_i (ent_vec[0]),
      .ent_o      (ent_vec[g]),
      .ge_ins_o   (ge_vec[g]),
      .flags_o    (flag_vec[g])
    );

    assign match_vec[g] = flag_vec[g].match;
    assign last_vec[g]  = flag_vec[g].last_match;
  end

  // ---------------- control ----------------
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    count_d      = count_q;
    status_d     = status_q;
    dump_idx_d   = dump_idx_q;
    load_rsp     = 1'b0;
    load_dump    = 1'b0;
    cmd.cmd      = CMD_HOLD;
    cmd.head_le  = flag_vec[0].ge_cmp;
    // head match wins over tail match
    cmd.del_last = !flag_vec[0].match && (|last_vec);
    cmd.ent      = ent_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = op_e'(req_i.operation);
          unique case (op_e'(req_i.operation))
            OP_INSERT, OP_DELETE: begin
              state_d = S_CMP;
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                dump_idx_d = '0;
                state_d    = S_DUMP;
              end
            end
            default: begin
              // unused code: drop the item
            end
          endcase
        end
      end
      S_CMP: begin
        cmd.cmd = CMD_CMP;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        state_d  = S_RESP;
        status_d = ST_OK;
        unique case (op_q)
          OP_INSERT: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              cmd.cmd = CMD_INSERT;
              count_d = count_q + CW'(1);
            end
          end
          OP_DELETE: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else if (!found) begin
              status_d = ST_NOT_FOUND;
            end else begin
              cmd.cmd = CMD_DELETE;
              count_d = count_q - CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_RESP: begin
        if (slot_free) begin
          load_rsp = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_DUMP: begin
        // emit cell 0 and rotate the row; count rotations restore the order
        if (slot_free) begin
          load_dump  = 1'b1;
          cmd.cmd    = CMD_ROTATE;
          dump_idx_d = dump_idx_q + IW'(1);
          if (dump_idx_q == last_idx) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_rsp || load_dump) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    status_q   <= status_d;
    dump_idx_q <= dump_idx_d;
    if (accept) begin
      ent_q.id        <= req_i.item_id;
      ent_q.name_low  <= req_i.name_low;
      ent_q.name_mid  <= req_i.name_mid;
      ent_q.name_high <= req_i.name_high;
      ent_q.stock     <= req_i.stock_amount;
    end
    if (load_rsp) begin
      rsp_ent_q    <= '0;
      rsp_status_q <= status_q;
      rsp_last_q   <= 1'b1;
    end else if (load_dump) begin
      rsp_ent_q    <= ent_vec[0];
      rsp_status_q <= ST_OK;
      rsp_last_q   <= dump_idx_q == last_idx;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.out_id        = rsp_ent_q.id;
  assign rsp_o.out_name_low  = rsp_ent_q.name_low;
  assign rsp_o.out_name_mid  = rsp_ent_q.name_mid;
  assign rsp_o.out_name_high = rsp_ent_q.name_high;
  assign rsp_o.out_stock     = rsp_ent_q.stock;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.last_result   = rsp_last_q;

  // ---------------- assertions ----------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY && op_q == OP_INSERT && !full)
    |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not add an entry");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY && op_q == OP_DELETE && count_q != '0 && found)
    |=> count_q == $past(count_q) - CW'(1))
    else $error("delete did not remove an entry");

  a_dump_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |=> $stable(count_q))
    else $error("entry count changed during dump");

endmodule
